// ----- hdl/scts_pkg.sv -----
// ----------------------------------------------------------------------------
// scts_pkg: shared types and constants of the sphere collider table scan
// command codes, status codes and the beat structs of both channels
// ----------------------------------------------------------------------------
package scts_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int COORD_BITS_DEF = 24;

  localparam logic [2:0] CMD_CREATE  = 3'd0;
  localparam logic [2:0] CMD_DESTROY = 3'd1;
  localparam logic [2:0] CMD_SETPOS  = 3'd2;
  localparam logic [2:0] CMD_SETRAD  = 3'd3;
  localparam logic [2:0] CMD_ENABLE  = 3'd4;
  localparam logic [2:0] CMD_DISABLE = 3'd5;
  localparam logic [2:0] CMD_SCAN    = 3'd6;

  localparam logic [2:0] ST_ALLOC  = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DONE   = 3'd2;
  localparam logic [2:0] ST_HIT    = 3'd3;
  localparam logic [2:0] ST_NOHIT  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         slot;
    logic [15:0]        entity_id;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [23:0]        radius_in;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot_out;
    logic [15:0] entity_a;
    logic [15:0] entity_b;
  } rsp_beat_t;

endpackage

// ----- hdl/scts_pair_test.sv -----
// ----------------------------------------------------------------------------
// scts_pair_test: pipelined sphere overlap test
// squared distance against squared radius sum, three register stages
// ----------------------------------------------------------------------------
module scts_pair_test #(
  parameter int COORD_BITS = scts_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] az,
  input  logic        [COORD_BITS-1:0] ar,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] bz,
  input  logic        [COORD_BITS-1:0] br,
  output logic                         hit
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;

  logic [DW-1:0] dx, dy, dz, rs;
  logic [PW-1:0] px, py, pz, pr;
  logic [SW-1:0] d2;
  logic [PW-1:0] r2;

  function automatic logic [DW-1:0] adiff(logic signed [COORD_BITS-1:0] a,
                                          logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  // stage 1: differences and radius sum
  always_ff @(posedge clk) begin
    dx <= adiff(ax, bx);
    dy <= adiff(ay, by);
    dz <= adiff(az, bz);
    rs <= DW'(ar) + DW'(br);
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    px <= dx * dx;
    py <= dy * dy;
    pz <= dz * dz;
    pr <= rs * rs;
  end

  // stage 3: sum of squares
  always_ff @(posedge clk) begin
    d2 <= SW'(px) + SW'(py) + SW'(pz);
    r2 <= pr;
  end

  assign hit = d2 < SW'(r2);
endmodule

// ----- hdl/scts_table.sv -----
// ----------------------------------------------------------------------------
// scts_table: collider storage, two synchronous read ports, one write port
// ----------------------------------------------------------------------------
module scts_table #(
  parameter int SLOTS      = scts_pkg::SLOTS_DEF,
  parameter int COORD_BITS = scts_pkg::COORD_BITS_DEF,
  localparam int AW = $clog2(SLOTS),
  localparam int EW = 16 + 4 * COORD_BITS + 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [EW-1:0] rdata_a,
  output logic [EW-1:0] rdata_b
);
  logic [EW-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

// ----- hdl/sphere_collider_table_scan_top.sv -----
// ----------------------------------------------------------------------------
// sphere_collider_table_scan_top: sphere collider table with pair scan
// one command beat in, one response beat out per command
// ----------------------------------------------------------------------------
//  channel   direction  payload      handshake
//  cmd       in         cmd_beat_t   cmd_valid / cmd_ready
//  rsp       out        rsp_beat_t   rsp_valid / rsp_ready
//
// update, enable, disable: read entry, wait, modify and write back; destroy
//   only clears the valid flag; all pass S_RD and S_WR to a waiting response beat
// create: walks the valid flags one slot a cycle up to the free slot, then
//   writes the new entry; a full table answers once the last slot is walked
// scan: one pair per cycle through the two table read ports and the
//   overlap pipeline; a hit answers with the pair's entities and ends the scan,
//   no hit answers once the last pair has drained from the pipeline
// reset clears the valid flags (flip-flops) and control state; table contents are free
// a new command is taken once idle and the response register is empty
// ----------------------------------------------------------------------------
module sphere_collider_table_scan_top #(
  parameter int SLOTS      = scts_pkg::SLOTS_DEF,
  parameter int COORD_BITS = scts_pkg::COORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  scts_pkg::cmd_beat_t cmd,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output scts_pkg::rsp_beat_t rsp
);
  localparam int AW  = $clog2(SLOTS);
  localparam int CW  = COORD_BITS;
  localparam int EW  = 16 + 4 * CW + 1;
  localparam int LAT = 4;  // read + three test stages

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIND  = 6'b000010,
    S_RD    = 6'b000100,
    S_WR    = 6'b001000,
    S_SCAN  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_t;

  state_t              state;
  scts_pkg::cmd_beat_t req;
  logic [SLOTS-1:0]    vflag;
  logic [AW-1:0]       idx_i, idx_j, tgt;
  logic                wait_rd;

  // table ports; entry = {enabled, entity, x, y, z, r}
  logic          we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, da, db;

  // scan pipeline tags
  logic [LAT-1:0]          pv;
  logic [AW-1:0]           pi_s;
  logic [AW-1:0]           pj_s;
  logic                    hit;
  logic [15:0]             ent_a, ent_b;
  logic                    last_issued;

  // eligibility and entities travel alongside the test stages
  logic [LAT-2:0] elig_d;
  logic [15:0]    ea_p [LAT-2];
  logic [15:0]    eb_p [LAT-2];
  logic [15:0]    ea_d, eb_d;

  logic in_range;
  assign in_range = (32'(req.slot) < SLOTS);
  assign cmd_ready = (state == S_IDLE) && !rsp_valid;

  scts_table #(.SLOTS(SLOTS), .COORD_BITS(COORD_BITS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr_a(ra), .raddr_b(rb), .rdata_a(da), .rdata_b(db)
  );

  scts_pair_test #(.COORD_BITS(COORD_BITS)) u_test (
    .clk(clk),
    .ax(da[4*CW-1:3*CW]), .ay(da[3*CW-1:2*CW]), .az(da[2*CW-1:CW]), .ar(da[CW-1:0]),
    .bx(db[4*CW-1:3*CW]), .by(db[3*CW-1:2*CW]), .bz(db[2*CW-1:CW]), .br(db[CW-1:0]),
    .hit(hit)
  );

  // a pair is eligible when both slots are valid and both enables read back set
  logic elig;
  assign elig = vflag[pi_s] && vflag[pj_s] && da[EW-1] && db[EW-1];

  // pair test leaving the pipeline, and the end of a scan with no hit
  logic hit_now, nohit_now;
  assign hit_now   = (state == S_SCAN || state == S_DRAIN) && pv[LAT-1] &&
                     elig_d[LAT-2] && hit;
  assign nohit_now = (state == S_DRAIN) && last_issued && (pv == '0);

  assign ra = (state == S_SCAN) ? idx_i : tgt;
  assign rb = idx_j;

  // write-back entry build
  always_comb begin
    we    = 1'b0;
    waddr = tgt;
    wdata = da;
    if (state == S_WR && !wait_rd) begin
      unique case (req.cmd)
        scts_pkg::CMD_CREATE: begin
          we = 1'b1;
          wdata = {1'b1, req.entity_id, {(4*CW){1'b0}}};
        end
        scts_pkg::CMD_SETPOS: begin
          we = in_range;
          wdata = {da[EW-1:4*CW], req.pos_x[CW-1:0], req.pos_y[CW-1:0],
                   req.pos_z[CW-1:0], da[CW-1:0]};
        end
        scts_pkg::CMD_SETRAD: begin
          we = in_range;
          wdata = {da[EW-1:CW], req.radius_in[CW-1:0]};
        end
        scts_pkg::CMD_ENABLE: begin
          we = in_range;
          wdata = {1'b1, da[EW-2:0]};
        end
        scts_pkg::CMD_DISABLE: begin
          we = in_range;
          wdata = {1'b0, da[EW-2:0]};
        end
        default: we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // scan tags line up with the registered read data
    pi_s <= idx_i;
    pj_s <= idx_j;
    if (pv[0]) begin
      ent_a <= da[EW-2:4*CW];
      ent_b <= db[EW-2:4*CW];
    end
    if (rst) begin
      state     <= S_IDLE;
      vflag     <= '0;
      rsp_valid <= 1'b0;
      pv        <= '0;
      wait_rd   <= 1'b0;
    end else begin
      // pv[0] marks read data of an issued pair; a hit flushes the rest
      pv <= hit_now ? '0 : {pv[LAT-2:0], state == S_SCAN};
      if (hit_now) begin
        rsp.status   <= scts_pkg::ST_HIT;
        rsp.entity_a <= ea_d;
        rsp.entity_b <= eb_d;
        rsp_valid    <= 1'b1;
        state        <= S_IDLE;
      end else if (nohit_now) begin
        rsp.status <= scts_pkg::ST_NOHIT;
        rsp_valid  <= 1'b1;
        state      <= S_IDLE;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (rsp_valid) begin
              if (rsp_ready) rsp_valid <= 1'b0;
            end else if (cmd_valid) begin
              req <= cmd;
              tgt <= (cmd.cmd == scts_pkg::CMD_CREATE) ? '0 : AW'(cmd.slot);
              rsp <= '{status: scts_pkg::ST_DONE, default: '0};
              if (cmd.cmd == scts_pkg::CMD_CREATE) begin
                state <= S_FIND;
              end else if (cmd.cmd == scts_pkg::CMD_SCAN) begin
                idx_i <= '0;
                idx_j <= AW'(1);
                last_issued <= 1'b0;
                state <= S_SCAN;
              end else begin
                state <= S_RD;
              end
            end
          end
          S_FIND: begin
            if (!vflag[tgt]) begin
              vflag[tgt] <= 1'b1;
              rsp.status <= scts_pkg::ST_ALLOC;
              rsp.slot_out <= 6'(tgt);
              wait_rd <= 1'b0;
              state <= S_WR;
            end else if (32'(tgt) == SLOTS - 1) begin
              rsp.status <= scts_pkg::ST_FULL;
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end else begin
              tgt <= tgt + AW'(1);
            end
          end
          S_RD: begin
            // destroy needs no table access
            if (req.cmd == scts_pkg::CMD_DESTROY && in_range) vflag[tgt] <= 1'b0;
            wait_rd <= 1'b1;
            state <= S_WR;
          end
          S_WR: begin
            // after S_RD, wait_rd holds the write back until the registered read data is there
            if (wait_rd) begin
              wait_rd <= 1'b0;
            end else begin
              rsp_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
          S_SCAN: begin
            if (32'(idx_j) == SLOTS - 1) begin
              if (32'(idx_i) == SLOTS - 2) begin
                last_issued <= 1'b1;
                state <= S_DRAIN;
              end else begin
                idx_i <= idx_i + AW'(1);
                idx_j <= idx_i + AW'(2);
              end
            end else begin
              idx_j <= idx_j + AW'(1);
            end
          end
          S_DRAIN: ;
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    elig_d <= {elig_d[LAT-3:0], pv[0] && elig};
    ea_p[0] <= ent_a;
    eb_p[0] <= ent_b;
    for (int k = 1; k < LAT - 2; k++) begin
      ea_p[k] <= ea_p[k-1];
      eb_p[k] <= eb_p[k-1];
    end
  end
  assign ea_d = ea_p[LAT-3];
  assign eb_d = eb_p[LAT-3];
endmodule
